// ===== hdl/scqec_pkg.sv =====
`default_nettype none
package scqec_pkg;

    localparam int COORD_BITS     = 20;
    localparam int POLY_VERTS_DEF = 4;
    localparam int MAX_PIECES     = 4;
    localparam int PIDX_W         = 2;
    localparam int CNT_W          = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int REG_LAST_IDX   = 7;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord seg_start_x;
        t_coord seg_start_y;
        t_coord seg_end_x;
        t_coord seg_end_y;
    } t_seg_in;

    typedef struct packed {
        t_coord piece_start_x;
        t_coord piece_start_y;
        t_coord piece_end_x;
        t_coord piece_end_y;
        logic   piece_valid;
        logic   last_piece;
    } t_piece_out;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_piece;

    typedef struct packed {
        logic                      vld;
        logic                      act;
        t_coord                    x1;
        t_coord                    y1;
        t_coord                    x2;
        t_coord                    y2;
        logic [CNT_W-1:0]          cnt;
        t_piece [MAX_PIECES-1:0]   pc;
    } t_walk;

endpackage
`default_nettype wire

// ===== hdl/segment_convex_quad_exterior_clip.sv =====
// Each segment passes through POLY_VERTS edge stages, then one output register.
// Each edge stage holds 4 arithmetic stages, 21 divider steps and one fix-up stage.
// Throughput: one segment per cycle when each yields one result and i_out_ready is high; a
// segment with n results holds the pipeline at the output register until all n are taken.
// Reset (i_rst_n low, synchronous) clears all vertices to zero and empties the pipeline.
`default_nettype none
module segment_convex_quad_exterior_clip #(
    parameter int POLY_VERTS = scqec_pkg::POLY_VERTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  scqec_pkg::t_seg_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output scqec_pkg::t_piece_out               o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [scqec_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  scqec_pkg::t_coord                   i_cfg_data
);
    import scqec_pkg::*;

    t_coord             r_vx [4];
    t_coord             r_vy [4];
    t_walk              w_walk [POLY_VERTS+1];
    t_walk              r_em;
    logic               r_em_vld;
    logic [PIDX_W-1:0]  r_idx;
    logic               em_last;
    logic               em_take;
    logic               en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_vx[i] <= '0;
                r_vy[i] <= '0;
            end
        end else if (i_cfg_valid && i_cfg_index <= CFG_IDX_W'(REG_LAST_IDX)) begin
            if (i_cfg_index[0]) begin
                r_vy[i_cfg_index[2:1]] <= i_cfg_data;
            end else begin
                r_vx[i_cfg_index[2:1]] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        w_walk[0]     = '0;
        w_walk[0].vld = i_in_valid;
        w_walk[0].act = 1'b1;
        w_walk[0].x1  = i_in_data.seg_start_x;
        w_walk[0].y1  = i_in_data.seg_start_y;
        w_walk[0].x2  = i_in_data.seg_end_x;
        w_walk[0].y2  = i_in_data.seg_end_y;
    end

    for (genvar j = 0; j < POLY_VERTS; j++) begin : g_edge
        localparam int PV = (j == 0) ? POLY_VERTS - 1 : j - 1;

        scqec_edge u_edge (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ax    (r_vx[PV]),
            .i_ay    (r_vy[PV]),
            .i_bx    (r_vx[j]),
            .i_by    (r_vy[j]),
            .i_walk  (w_walk[j]),
            .o_walk  (w_walk[j+1])
        );
    end

    assign em_last = (r_em.cnt == '0) || (CNT_W'(r_idx) == r_em.cnt - CNT_W'(1));
    assign em_take = !r_em_vld || (i_out_ready && em_last);
    assign en      = !w_walk[POLY_VERTS].vld || em_take;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_vld <= 1'b0;
            r_idx    <= '0;
        end else if (em_take) begin
            r_em_vld <= w_walk[POLY_VERTS].vld;
            r_em     <= w_walk[POLY_VERTS];
            r_idx    <= '0;
        end else if (i_out_ready) begin
            r_idx <= r_idx + PIDX_W'(1);
        end
    end

    assign o_out_valid = r_em_vld;

    always_comb begin
        o_out_data = '0;
        o_out_data.last_piece = em_last;
        if (r_em.cnt != '0) begin
            o_out_data.piece_start_x = r_em.pc[r_idx].sx;
            o_out_data.piece_start_y = r_em.pc[r_idx].sy;
            o_out_data.piece_end_x   = r_em.pc[r_idx].ex;
            o_out_data.piece_end_y   = r_em.pc[r_idx].ey;
            o_out_data.piece_valid   = 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/scqec_edge.sv =====
`default_nettype none
module scqec_edge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  scqec_pkg::t_coord   i_ax,
    input  scqec_pkg::t_coord   i_ay,
    input  scqec_pkg::t_coord   i_bx,
    input  scqec_pkg::t_coord   i_by,
    input  scqec_pkg::t_walk    i_walk,
    output scqec_pkg::t_walk    o_walk
);
    import scqec_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int NW    = W + 1;
    localparam int PW    = 2 * W + 1;
    localparam int DSW   = 2 * W + 2;
    localparam int DW    = 2 * W + 3;
    localparam int TW    = DW + 2;
    localparam int STEPS = NW;

    typedef struct packed {
        t_walk           w;
        logic            in1;
        logic            in2;
        logic            negx;
        logic            negy;
        logic [DW-1:0]   num;
        logic [DW-1:0]   den;
        logic [NW-1:0]   mx;
        logic [NW-1:0]   my;
        logic [DW-1:0]   rx;
        logic [DW-1:0]   ry;
        logic [NW-1:0]   qx;
        logic [NW-1:0]   qy;
    } t_dstep;

    function automatic logic [DW+NW-1:0] div_step(
        input logic [DW-1:0] rem,
        input logic [DW-1:0] num,
        input logic [DW-1:0] den,
        input logic          b,
        input logic [NW-1:0] q
    );
        logic [TW-1:0] t;
        logic [TW-1:0] dn1;
        logic [TW-1:0] dn2;
        logic [NW-1:0] qs;
        t   = (TW'(rem) << 1) + (b ? TW'(num) : TW'(0));
        dn1 = TW'(den);
        dn2 = dn1 << 1;
        qs  = q << 1;
        if (t >= dn2) begin
            return {DW'(t - dn2), qs + NW'(2)};
        end else if (t >= dn1) begin
            return {DW'(t - dn1), qs + NW'(1)};
        end else begin
            return {DW'(t), qs};
        end
    endfunction

    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;

    assign nx = NW'(i_ay) - NW'(i_by);
    assign ny = NW'(i_bx) - NW'(i_ax);

    t_walk              r0_w;
    logic signed [PW-1:0] r0_pxa, r0_pya, r0_px1, r0_py1, r0_px2, r0_py2;
    t_walk              r1_w;
    logic signed [DSW-1:0] r1_dist, r1_d1, r1_d2;
    t_walk              r2_w;
    logic               r2_in1, r2_in2;
    logic signed [DW-1:0] r2_num, r2_den;
    logic signed [NW-1:0] r2_dx, r2_dy;
    t_dstep             r_st [STEPS+1];
    t_walk              r_out;
    t_walk              n_w;
    logic [NW-1:0]      cxw, cyw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_w.vld <= 1'b0;
            r1_w.vld <= 1'b0;
            r2_w.vld <= 1'b0;
        end else if (i_en) begin
            r0_w   <= i_walk;
            r0_pxa <= PW'(nx) * PW'(i_ax);
            r0_pya <= PW'(ny) * PW'(i_ay);
            r0_px1 <= PW'(nx) * PW'(i_walk.x1);
            r0_py1 <= PW'(ny) * PW'(i_walk.y1);
            r0_px2 <= PW'(nx) * PW'(i_walk.x2);
            r0_py2 <= PW'(ny) * PW'(i_walk.y2);

            r1_w    <= r0_w;
            r1_dist <= DSW'(r0_pxa) + DSW'(r0_pya);
            r1_d1   <= DSW'(r0_px1) + DSW'(r0_py1);
            r1_d2   <= DSW'(r0_px2) + DSW'(r0_py2);

            r2_w   <= r1_w;
            r2_in1 <= r1_d1 > r1_dist;
            r2_in2 <= r1_d2 > r1_dist;
            r2_num <= DW'(r1_dist) - DW'(r1_d1);
            r2_den <= DW'(r1_d2) - DW'(r1_d1);
            r2_dx  <= NW'(r1_w.x2) - NW'(r1_w.x1);
            r2_dy  <= NW'(r1_w.y2) - NW'(r1_w.y1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].w.vld <= 1'b0;
        end else if (i_en) begin
            r_st[0].w    <= r2_w;
            r_st[0].in1  <= r2_in1;
            r_st[0].in2  <= r2_in2;
            r_st[0].negx <= r2_dx[NW-1] ^ r2_num[DW-1] ^ r2_den[DW-1];
            r_st[0].negy <= r2_dy[NW-1] ^ r2_num[DW-1] ^ r2_den[DW-1];
            r_st[0].num  <= r2_num[DW-1] ? DW'(-r2_num) : DW'(r2_num);
            r_st[0].den  <= r2_den[DW-1] ? DW'(-r2_den) : DW'(r2_den);
            r_st[0].mx   <= r2_dx[NW-1] ? NW'(-r2_dx) : NW'(r2_dx);
            r_st[0].my   <= r2_dy[NW-1] ? NW'(-r2_dy) : NW'(r2_dy);
            r_st[0].rx   <= '0;
            r_st[0].ry   <= '0;
            r_st[0].qx   <= '0;
            r_st[0].qy   <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        t_dstep n_st;

        always_comb begin
            n_st = r_st[k];
            {n_st.rx, n_st.qx} = div_step(r_st[k].rx, r_st[k].num, r_st[k].den,
                                          r_st[k].mx[STEPS-1-k], r_st[k].qx);
            {n_st.ry, n_st.qy} = div_step(r_st[k].ry, r_st[k].num, r_st[k].den,
                                          r_st[k].my[STEPS-1-k], r_st[k].qy);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k+1].w.vld <= 1'b0;
            end else if (i_en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    always_comb begin
        cxw = r_st[STEPS].negx ? (NW'(r_st[STEPS].w.x1) - r_st[STEPS].qx)
                               : (NW'(r_st[STEPS].w.x1) + r_st[STEPS].qx);
        cyw = r_st[STEPS].negy ? (NW'(r_st[STEPS].w.y1) - r_st[STEPS].qy)
                               : (NW'(r_st[STEPS].w.y1) + r_st[STEPS].qy);
        n_w = r_st[STEPS].w;
        if (n_w.vld && n_w.act) begin
            if (!r_st[STEPS].in1 && !r_st[STEPS].in2) begin
                n_w.pc[n_w.cnt[PIDX_W-1:0]] = '{sx: n_w.x1, sy: n_w.y1,
                                                 ex: n_w.x2, ey: n_w.y2};
                n_w.cnt = n_w.cnt + CNT_W'(1);
                n_w.act = 1'b0;
            end else if (r_st[STEPS].in1 != r_st[STEPS].in2) begin
                if (r_st[STEPS].in1) begin
                    n_w.pc[n_w.cnt[PIDX_W-1:0]] = '{sx: cxw[W-1:0], sy: cyw[W-1:0],
                                                     ex: n_w.x2, ey: n_w.y2};
                    n_w.x2 = cxw[W-1:0];
                    n_w.y2 = cyw[W-1:0];
                end else begin
                    n_w.pc[n_w.cnt[PIDX_W-1:0]] = '{sx: n_w.x1, sy: n_w.y1,
                                                     ex: cxw[W-1:0], ey: cyw[W-1:0]};
                    n_w.x1 = cxw[W-1:0];
                    n_w.y1 = cyw[W-1:0];
                end
                n_w.cnt = n_w.cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (i_en) begin
            r_out <= n_w;
        end
    end

    assign o_walk = r_out;

endmodule
`default_nettype wire

// ===== hdl/scqec_check.sv =====
`default_nettype none
module scqec_check (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               o_in_ready,
    input  wire scqec_pkg::t_seg_in                 i_in_data,
    input  wire logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    input  wire scqec_pkg::t_piece_out              o_out_data,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               o_cfg_ready,
    input  wire logic [scqec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire scqec_pkg::t_coord                  i_cfg_data
);
    import scqec_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.piece_valid |-> o_out_data.last_piece)
        else $error("empty result not marked last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.piece_valid |->
            o_out_data.piece_start_x == '0 && o_out_data.piece_start_y == '0 &&
            o_out_data.piece_end_x == '0 && o_out_data.piece_end_y == '0)
        else $error("empty result carries coordinates");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind segment_convex_quad_exterior_clip scqec_check u_scqec_check (.*);
`default_nettype wire
